// ===== src/iks_pkg.sv =====
// Shared types and constants for the id-keyed slot table.
package iks_pkg;

    // Default sizes of the table.
    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int RECORD_WIDTH_DEF = 64;

    // Fixed widths of the transaction fields.
    localparam int CMD_W        = 3;
    localparam int ID_W         = 16;
    localparam int REC_FIELD_W  = 64;
    localparam int CODE_W       = 2;
    localparam int SLOT_FIELD_W = 4;

    // Slot status values.
    localparam logic SLOT_FREE = 1'b0;
    localparam logic SLOT_USED = 1'b1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

    // Result codes.
    localparam logic [CODE_W-1:0] RC_OK        = 2'd0;
    localparam logic [CODE_W-1:0] RC_FULL      = 2'd1;
    localparam logic [CODE_W-1:0] RC_NOT_FOUND = 2'd2;

    // Request transaction payload.
    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [ID_W-1:0]        key_id;
        logic [REC_FIELD_W-1:0] record_in;
    } iks_req_t;

    // Response transaction payload.
    typedef struct packed {
        logic [CODE_W-1:0]       result_code;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [ID_W-1:0]         assigned_id;
        logic [REC_FIELD_W-1:0]  record_out;
    } iks_rsp_t;

    // Decoded operation broadcast to every cell.
    typedef struct packed {
        logic                   go;
        logic                   clear;
        logic                   insert;
        logic                   remove;
        logic                   modify;
        logic                   find;
        logic [ID_W-1:0]        key_id;
        logic [ID_W-1:0]        new_id;
        logic [REC_FIELD_W-1:0] record;
    } iks_op_t;

    // Priority link handed from cell to cell.
    typedef struct packed {
        logic                    taken;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [ID_W-1:0]         id;
    } iks_link_t;

endpackage

// ===== src/iks_cell.sv =====
// One slot of the table: holds valid, id and record, and claims the op in priority order.
module iks_cell
    import iks_pkg::*;
#(
    parameter int RECORD_WIDTH = RECORD_WIDTH_DEF,
    parameter int CELL_IDX     = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  iks_op_t                 op,
    input  iks_link_t               link_in,
    input  logic [RECORD_WIDTH-1:0] rec_in,
    output iks_link_t               link_out,
    output logic [RECORD_WIDTH-1:0] rec_out
);

    localparam logic [SLOT_FIELD_W-1:0] SLOT_CODE = SLOT_FIELD_W'(CELL_IDX);

    logic                    valid_reg;
    logic                    valid_next;
    logic [ID_W-1:0]         id_reg;
    logic [RECORD_WIDTH-1:0] record_reg;
    logic                    is_free;
    logic                    is_match;
    logic                    claim;

    // A cell claims the op if free (insert) or matching (others) and no lower cell has.
    assign is_free  = (valid_reg == SLOT_FREE);
    assign is_match = (valid_reg == SLOT_USED) && (id_reg == op.key_id);
    assign claim    = !link_in.taken &&
                      ((op.insert && is_free) ||
                       ((op.remove || op.modify || op.find) && is_match));

    // Pass the link on, replacing it with this slot when it wins.
    always_comb
    begin
        link_out = link_in;
        rec_out  = rec_in;
        if (claim)
        begin
            link_out.taken      = 1'b1;
            link_out.slot_index = SLOT_CODE;
            link_out.id         = op.insert ? op.new_id : id_reg;
            rec_out             = op.find ? record_reg : '0;
        end
    end

    // Next status of the slot.
    always_comb
    begin
        valid_next = valid_reg;
        if (op.go)
        begin
            if (op.clear)
                valid_next = SLOT_FREE;
            else if (claim && op.insert)
                valid_next = SLOT_USED;
            else if (claim && op.remove)
                valid_next = SLOT_FREE;
        end
    end

    // Status flag is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= SLOT_FREE;
        else
            valid_reg <= valid_next;
    end

    // Id and record are written only when the slot is claimed.
    always_ff @(posedge clk)
    begin
        if (op.go && claim && op.insert)
            id_reg <= op.new_id;
        if (op.go && claim && (op.insert || op.modify))
            record_reg <= op.record[RECORD_WIDTH-1:0];
    end

endmodule

// ===== src/id_keyed_slot_table.sv =====
// Top level of the id-keyed slot table: command sequencer, cell chain and response register.
//
// Usage: a request transaction (req) carries a command, a key id and a record.
// Clear frees every slot; insert stores the record in the lowest free slot under
// the next id of a counter that wraps from its maximum to 1; remove, modify and
// find act on the lowest valid slot whose id equals the key. Exactly one response
// transaction (rsp) follows each request.
// Execution: an accepted request is held in the request register and executes in
// the execute state; its response is then registered in the response register.
// No new request is taken while one executes: the op ripples through the row of
// cells in the execute state, and the winning slot is picked by the priority link.
// The response register parts the two sides: a new request is taken while an
// earlier response still waits; if the receiver stalls, the next request waits
// in its execute cycle until the response register is free, and the stalled
// response holds steady.
// Reset frees every slot, clears the id counter and empties both channels.
module id_keyed_slot_table
    import iks_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int RECORD_WIDTH = RECORD_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  iks_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output iks_rsp_t rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    iks_req_t        req_reg;
    logic [ID_W-1:0] id_counter_reg;
    logic [ID_W-1:0] id_counter_next;
    logic [ID_W-1:0] id_candidate;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    iks_rsp_t        rsp_reg;
    iks_rsp_t        rsp_next;
    logic            req_accept;
    logic            exec_go;
    iks_op_t         op;

    iks_link_t               link_chain [TABLE_DEPTH+1];
    logic [RECORD_WIDTH-1:0] rec_chain  [TABLE_DEPTH+1];

    // Handshake.
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign exec_go    = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Next id from the running counter; zero is skipped on wrap.
    assign id_candidate = (id_counter_reg == '1) ? ID_W'(1) : id_counter_reg + ID_W'(1);

    // Decode the held command into the broadcast op.
    always_comb
    begin
        op        = '0;
        op.go     = exec_go;
        op.key_id = req_reg.key_id;
        op.new_id = id_candidate;
        op.record = req_reg.record_in;
        unique case (req_reg.command)
            CMD_CLEAR:  op.clear  = 1'b1;
            CMD_INSERT: op.insert = 1'b1;
            CMD_REMOVE: op.remove = 1'b1;
            CMD_MODIFY: op.modify = 1'b1;
            CMD_FIND:   op.find   = 1'b1;
            default:    op.go     = exec_go;
        endcase
    end

    // Row of slot cells linked in priority order, slot zero first.
    assign link_chain[0] = '0;
    assign rec_chain[0]  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        iks_cell #(
            .RECORD_WIDTH (RECORD_WIDTH),
            .CELL_IDX     (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .link_in  (link_chain[i]),
            .rec_in   (rec_chain[i]),
            .link_out (link_chain[i+1]),
            .rec_out  (rec_chain[i+1])
        );
    end

    // Response contents and counter update for the executing command.
    always_comb
    begin
        rsp_next        = '0;
        id_counter_next = id_counter_reg;
        if (op.insert || op.remove || op.modify || op.find)
        begin
            if (link_chain[TABLE_DEPTH].taken)
            begin
                rsp_next.result_code = RC_OK;
                rsp_next.slot_index  = link_chain[TABLE_DEPTH].slot_index;
                rsp_next.assigned_id = link_chain[TABLE_DEPTH].id;
                rsp_next.record_out  = REC_FIELD_W'(rec_chain[TABLE_DEPTH]);
                if (op.insert)
                    id_counter_next = id_candidate;
            end
            else
            begin
                rsp_next.result_code = op.insert ? RC_FULL : RC_NOT_FOUND;
            end
        end
    end

    // Sequencer next state and response valid.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
                if (req_accept)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State, counter and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            id_counter_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_go)
                id_counter_reg <= id_counter_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
            req_reg <= req;
        if (exec_go)
            rsp_reg <= rsp_next;
    end

    // A failed response carries no slot, id or record.
    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.result_code != RC_OK) |->
            (rsp_reg.slot_index == '0 && rsp_reg.assigned_id == '0 &&
             rsp_reg.record_out == '0))
        else $error("failed response carries nonzero fields");

    // The id counter moves only on an executed insert.
    a_counter_moves_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && !op.insert) |=> $stable(id_counter_reg))
        else $error("id counter changed without an insert");

    // With the response register free, the next cycle is idle with the response valid.
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !rsp_valid_reg) |=>
            (state_reg == ST_IDLE && rsp_valid_reg))
        else $error("execute cycle did not complete");

    // A successful insert never hands out id zero.
    a_insert_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && op.insert && link_chain[TABLE_DEPTH].taken) |=>
            (rsp_reg.assigned_id != '0))
        else $error("insert handed out id zero");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the id-keyed slot table: directed table and random traffic.
module tb_top
    import iks_pkg::*;
();

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 1360;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRESSURE_AT  = 300;
    localparam int PRESSURE_LEN = 250;

    // Spare command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [REC_FIELD_W-1:0] REC_ONES = {REC_FIELD_W{1'b1}};
    localparam logic [REC_FIELD_W-1:0] REC_ZERO = '0;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    iks_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    iks_rsp_t rsp;

    id_keyed_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Shadow copy of the table and the id counter.
    logic                   tbl_live [DEPTH];
    logic [ID_W-1:0]        tbl_id   [DEPTH];
    logic [REC_FIELD_W-1:0] tbl_rec  [DEPTH];
    logic [ID_W-1:0]        id_ctr;

    // Responses still owed by the block, oldest first.
    iks_rsp_t replies_due [$];

    int errors;
    bit calm_tx;
    bit calm_rx;

    // One row of the directed stimulus table.
    typedef struct {
        iks_req_t req;
        bit       known;
        iks_rsp_t rsp;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // Apply one command to the shadow table and return the response it causes.
    function automatic iks_rsp_t table_exec(iks_req_t r);
        iks_rsp_t o;
        int       hit;
        o   = '0;
        hit = -1;
        case (r.command)
            CMD_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    tbl_live[i] = SLOT_FREE;
            end
            CMD_INSERT:
            begin
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (tbl_live[i] == SLOT_FREE)
                        hit = i;
                if (hit < 0)
                    o.result_code = RC_FULL;
                else
                begin
                    id_ctr = id_ctr + 1'b1;
                    if (id_ctr == '0)
                        id_ctr = ID_W'(1);
                    tbl_live[hit] = SLOT_USED;
                    tbl_id[hit]   = id_ctr;
                    tbl_rec[hit]  = r.record_in;
                    o.result_code = RC_OK;
                    o.slot_index  = SLOT_FIELD_W'(hit);
                    o.assigned_id = id_ctr;
                end
            end
            CMD_REMOVE, CMD_MODIFY, CMD_FIND:
            begin
                // The lowest live slot with a matching id wins.
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (tbl_live[i] == SLOT_USED && tbl_id[i] == r.key_id)
                        hit = i;
                if (hit < 0)
                    o.result_code = RC_NOT_FOUND;
                else
                begin
                    o.result_code = RC_OK;
                    o.slot_index  = SLOT_FIELD_W'(hit);
                    o.assigned_id = tbl_id[hit];
                    if (r.command == CMD_REMOVE)
                        tbl_live[hit] = SLOT_FREE;
                    else if (r.command == CMD_MODIFY)
                        tbl_rec[hit] = r.record_in;
                    else
                        o.record_out = tbl_rec[hit];
                end
            end
            default:
            begin
                // Spare codes leave the table alone and answer with zeros.
            end
        endcase
        return o;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_live[i] == SLOT_USED)
                n++;
        return n;
    endfunction

    // Id of a random live slot, or any id when the table is empty.
    function automatic logic [ID_W-1:0] live_id();
        int picks [$];
        for (int i = 0; i < DEPTH; i++)
            if (tbl_live[i] == SLOT_USED)
                picks.push_back(i);
        if (picks.size() == 0)
            return ID_W'($urandom);
        return tbl_id[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    function automatic logic [REC_FIELD_W-1:0] rand_rec();
        case ($urandom_range(0, 9))
            0:       return REC_ONES;
            1:       return REC_ZERO;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random command, mostly aimed at ids that are live.
    function automatic iks_req_t mixed_req();
        iks_req_t r;
        int       p;
        int       q;
        p = $urandom_range(0, 99);
        q = $urandom_range(0, 9);
        r.record_in = rand_rec();
        if (p < 30)
            r.command = CMD_INSERT;
        else if (p < 50)
            r.command = CMD_REMOVE;
        else if (p < 70)
            r.command = CMD_MODIFY;
        else if (p < 95)
            r.command = CMD_FIND;
        else if (p < 97)
            r.command = CMD_CLEAR;
        else if (p < 98)
            r.command = CMD_SPARE_5;
        else if (p < 99)
            r.command = CMD_SPARE_6;
        else
            r.command = CMD_SPARE_7;
        if (q < 7)
            r.key_id = live_id();
        else if (q < 8)
            r.key_id = id_ctr + ID_W'($urandom_range(0, 2));
        else
            r.key_id = ID_W'($urandom);
        return r;
    endfunction

    // Idle cycles before the next request: mostly none or short, a few long.
    function automatic int next_gap();
        int p;
        if ($urandom_range(0, 149) == 0)
            calm_tx = !calm_tx;
        if (calm_tx)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // Offer one request, wait for acceptance, then record the response it owes.
    task automatic send_req(input iks_req_t r, input bit known, input iks_rsp_t golden);
        int       gap;
        iks_rsp_t predicted;
        gap = next_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = table_exec(r);
        replies_due.push_back(known ? golden : predicted);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] key,
                            input logic [REC_FIELD_W-1:0] rec);
        iks_req_t r;
        r.command   = cmd;
        r.key_id    = key;
        r.record_in = rec;
        send_req(r, 1'b0, '0);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] key,
                           input logic [REC_FIELD_W-1:0] rec, input bit known,
                           input logic [CODE_W-1:0] code, input logic [SLOT_FIELD_W-1:0] slot,
                           input logic [ID_W-1:0] id, input logic [REC_FIELD_W-1:0] rout);
        dir_row_t row;
        row.req.command     = cmd;
        row.req.key_id      = key;
        row.req.record_in   = rec;
        row.known           = known;
        row.rsp.result_code = code;
        row.rsp.slot_index  = slot;
        row.rsp.assigned_id = id;
        row.rsp.record_out  = rout;
        dir_rows.push_back(row);
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Compare one accepted response with the oldest one owed.
    task automatic check_reply(input iks_rsp_t got);
        iks_rsp_t want;
        if (replies_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %0h", $time, got);
            return;
        end
        want = replies_due.pop_front();
        if (got.result_code !== want.result_code)
            report_field("result_code", 64'(want.result_code), 64'(got.result_code));
        if (got.slot_index !== want.slot_index)
            report_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
        if (got.assigned_id !== want.assigned_id)
            report_field("assigned_id", 64'(want.assigned_id), 64'(got.assigned_id));
        if (got.record_out !== want.record_out)
            report_field("record_out", want.record_out, got.record_out);
    endtask

    // Response side: check each transaction and stall at random.
    int stall_left;
    int replies_seen;
    int rx_roll;
    bit pressure_done;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_reply(rsp);
                replies_seen++;
            end
            // One long hold-off so that the block backs up into its input.
            if (!pressure_done && replies_seen == PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_LEN;
            end
            if ($urandom_range(0, 199) == 0)
                calm_rx = !calm_rx;
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else if (calm_rx)
                rsp_stall <= 1'b0;
            else
            begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 60)
                    rsp_stall <= 1'b0;
                else
                begin
                    rsp_stall  <= 1'b1;
                    stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial
    begin
        int          n_items;
        int          scene;
        iks_req_t    r;

        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        errors    = 0;
        id_ctr    = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_live[i] = SLOT_FREE;
            tbl_id[i]   = '0;
            tbl_rec[i]  = '0;
        end

        // Directed table: known answers where they are plain, the shadow table elsewhere.
        add_row(CMD_FIND,    16'd0,    REC_ZERO, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_INSERT,  16'hFFFF, REC_ONES, 1'b1, RC_OK,        4'd0, 16'd1, REC_ZERO);
        add_row(CMD_INSERT,  16'd0,    REC_ZERO, 1'b1, RC_OK,        4'd1, 16'd2, REC_ZERO);
        add_row(CMD_FIND,    16'd1,    REC_ZERO, 1'b1, RC_OK,        4'd0, 16'd1, REC_ONES);
        add_row(CMD_MODIFY,  16'd2,    REC_ONES, 1'b1, RC_OK,        4'd1, 16'd2, REC_ZERO);
        add_row(CMD_FIND,    16'd2,    REC_ZERO, 1'b1, RC_OK,        4'd1, 16'd2, REC_ONES);
        add_row(CMD_REMOVE,  16'd1,    REC_ONES, 1'b1, RC_OK,        4'd0, 16'd1, REC_ZERO);
        add_row(CMD_FIND,    16'd1,    REC_ONES, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_MODIFY,  16'd1,    REC_ONES, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_REMOVE,  16'd1,    REC_ZERO, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_INSERT,  16'd0, 64'h0123_4567_89AB_CDEF, 1'b1, RC_OK, 4'd0, 16'd3,
                REC_ZERO);
        add_row(CMD_SPARE_5, 16'hFFFF, REC_ONES, 1'b1, RC_OK,        4'd0, 16'd0, REC_ZERO);
        add_row(CMD_SPARE_6, 16'd2,    REC_ONES, 1'b1, RC_OK,        4'd0, 16'd0, REC_ZERO);
        add_row(CMD_SPARE_7, 16'd3,    REC_ZERO, 1'b1, RC_OK,        4'd0, 16'd0, REC_ZERO);
        add_row(CMD_FIND,    16'hFFFF, REC_ONES, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_FIND,    16'd3,    REC_ZERO, 1'b0, RC_OK,        4'd0, 16'd0, REC_ZERO);
        add_row(CMD_CLEAR,   16'hFFFF, REC_ONES, 1'b1, RC_OK,        4'd0, 16'd0, REC_ZERO);
        add_row(CMD_FIND,    16'd2,    REC_ZERO, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_INSERT,  16'h8000, REC_ONES, 1'b1, RC_OK,        4'd0, 16'd4, REC_ZERO);
        add_row(CMD_REMOVE,  16'd0,    REC_ZERO, 1'b1, RC_NOT_FOUND, 4'd0, 16'd0, REC_ZERO);
        add_row(CMD_FIND,    16'd4,    REC_ZERO, 1'b0, RC_OK,        4'd0, 16'd0, REC_ZERO);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);

        // Random traffic: fill-to-full runs, drain runs and mixed command bursts.
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            scene = $urandom_range(0, 9);
            if (scene == 0)
            begin
                while (live_count() < DEPTH)
                begin
                    send_cmd(CMD_INSERT, ID_W'($urandom), rand_rec());
                    n_items++;
                end
                repeat (2)
                begin
                    send_cmd(CMD_INSERT, ID_W'($urandom), rand_rec());
                    n_items++;
                end
            end
            else if (scene == 1)
            begin
                while (live_count() > 0)
                begin
                    send_cmd(CMD_REMOVE, live_id(), rand_rec());
                    n_items++;
                end
            end
            else
            begin
                repeat (20)
                begin
                    r = mixed_req();
                    send_req(r, 1'b0, '0);
                    if (r.command <= CMD_FIND)
                        n_items++;
                end
            end
        end

        // A closing burst of mixed commands.
        repeat (60)
        begin
            r = mixed_req();
            send_req(r, 1'b0, '0);
        end

        // Let every owed response come back, then settle.
        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
src/iks_pkg.sv
src/iks_cell.sv
src/id_keyed_slot_table.sv
tb/tb_top.sv
